/* hw/rtl/atha_pkg.sv */
// shared types, constants and helper functions for the attitude to haptic amplitude unit
package atha_pkg;

    // default ring size and fixed arithmetic constants
    localparam int POD_COUNT_DEF = 8;
    localparam logic [15:0] Q15_FULL = 16'd32767;
    localparam logic [15:0] DEADBAND_RESET = 16'd350;
    localparam logic [15:0] FULL_SCALE_RESET = 16'd3500;
    localparam logic [7:0] MAX_AMP_RESET = 8'd96;

    // configuration register indexes
    localparam logic [1:0] CFG_DEADBAND = 2'd0;
    localparam logic [1:0] CFG_FULL_SCALE = 2'd1;
    localparam logic [1:0] CFG_MAX_AMP = 2'd2;

    // divider sizes: numerator (mag - deadband) * 32767, quotient below 2^15
    localparam int DIV_N_W = 31;
    localparam int DIV_D_W = 16;
    localparam int DIV_Q_W = 15;

    // input request payload
    typedef struct packed {
        logic              cmd;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic [2:0]        row_pod;
        logic signed [15:0] row_pitch_weight;
        logic signed [15:0] row_roll_weight;
        logic signed [15:0] row_yaw_weight;
    } in_item_t;

    // result request payload
    typedef struct packed {
        logic [2:0] pod_index;
        logic [7:0] amplitude;
        logic       last_pod;
    } out_item_t;

    // one stored weight row
    typedef struct packed {
        logic signed [15:0] pitch_w;
        logic signed [15:0] roll_w;
        logic signed [15:0] yaw_w;
    } weight_row_t;

    // divider control and status
    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] numer;
        logic [DIV_D_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_AXDIV,
        ST_RD,
        ST_MAC,
        ST_MIXDIV,
        ST_AMPMUL,
        ST_AMPDIV
    } state_t;

    // bring-up geometry rows, pods past the eighth are zero
    function automatic weight_row_t bringup_row(input logic [7:0] pod);
        weight_row_t r;
        r = '0;
        case (pod)
            8'd0: r.pitch_w = $signed(Q15_FULL);
            8'd1: r.yaw_w = $signed(Q15_FULL);
            8'd2: r.roll_w = $signed(Q15_FULL);
            8'd4: r.pitch_w = -$signed(Q15_FULL);
            8'd5: r.yaw_w = -$signed(Q15_FULL);
            8'd6: r.roll_w = -$signed(Q15_FULL);
            default: r = '0;
        endcase
        return r;
    endfunction

    // floor(x / 32767) by folding base 2^15 digits, one final correction
    function automatic logic [17:0] div_q15_full(input logic [31:0] x);
        logic [16:0] q0;
        logic [17:0] r0;
        logic [2:0]  q1;
        logic [15:0] r1;
        logic        c;
        q0 = x[31:15];
        r0 = {3'b000, x[14:0]} + {1'b0, q0};
        q1 = r0[17:15];
        r1 = {1'b0, r0[14:0]} + {13'd0, q1};
        c = (r1 >= Q15_FULL);
        return {1'b0, q0} + {15'd0, q1} + {17'd0, c};
    endfunction

endpackage

/* hw/rtl/atha_weight_ram.sv */
// weight row memory with per-row valid bits that fall back to bring-up geometry
module atha_weight_ram #(
    parameter int DEPTH = atha_pkg::POD_COUNT_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  atha_pkg::weight_row_t wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output atha_pkg::weight_row_t rdata
);

    atha_pkg::weight_row_t mem [DEPTH];
    logic [DEPTH-1:0]      valid_reg;
    atha_pkg::weight_row_t rdata_reg;

    // row valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // row storage
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, unwritten rows read as bring-up geometry
    always_ff @(posedge aclk) begin
        if (valid_reg[raddr]) begin
            rdata_reg <= mem[raddr];
        end else begin
            rdata_reg <= atha_pkg::bringup_row(8'(raddr));
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/atha_div.sv */
// restoring divider, one quotient bit per cycle, for the axis scaling
module atha_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  atha_pkg::div_req_t req,
    output atha_pkg::div_rsp_t rsp
);

    localparam int N_W = atha_pkg::DIV_N_W;
    localparam int D_W = atha_pkg::DIV_D_W;
    localparam int Q_W = atha_pkg::DIV_Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   bits_reg, bits_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W:0]     trial;

    // one shift-compare-subtract step per cycle
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        bits_next = bits_reg;
        quot_next = quot_reg;
        den_next = den_reg;
        trial = {rem_reg, bits_reg[Q_W-1]};
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(Q_W);
            rem_next = req.numer[N_W-1:Q_W];
            bits_next = req.numer[Q_W-1:0];
            den_next = req.denom;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = D_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[Q_W-2:0], 1'b1};
            end else begin
                rem_next = trial[D_W-1:0];
                quot_next = {quot_reg[Q_W-2:0], 1'b0};
            end
            bits_next = {bits_reg[Q_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        bits_reg <= bits_next;
        quot_reg <= quot_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* hw/rtl/attitude_to_haptic_amplitudes_unit.sv */
// top level: attitude sample sequencer with shared multiplier and divider
// Each accepted sample scales its three axes in turn: an axis at or below the deadband or
// at or past full scale is set directly, any other one runs through the bit-serial divider;
// then each pod in turn passes the shared 18x18 multiplier and the constant divide by 32767.
// One sample is in work at a time; the next request is taken the cycle after the last pod
// is queued, and a stalled result holds the sequencer; a row write leaves the block idle.
// Synchronous active-low reset restores the register defaults and bring-up weight rows.
module attitude_to_haptic_amplitudes_unit #(
    parameter int POD_COUNT = atha_pkg::POD_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  atha_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output atha_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int POD_W = (POD_COUNT > 1) ? $clog2(POD_COUNT) : 1;
    localparam logic [POD_W-1:0] LAST_POD = POD_W'(POD_COUNT - 1);

    atha_pkg::state_t    state_reg, state_next;
    logic [15:0]         deadband_reg, full_scale_reg;
    logic [7:0]          max_amp_reg;
    logic signed [15:0]  angle_reg [3];
    logic signed [15:0]  angle_next [3];
    logic signed [15:0]  axis_reg [3];
    logic signed [15:0]  axis_next [3];
    logic [1:0]          axis_idx_reg, axis_idx_next;
    logic                axis_neg_reg, axis_neg_next;
    logic [POD_W-1:0]    pod_reg, pod_next;
    logic [1:0]          term_reg, term_next;
    logic signed [31:0]  prod_reg, prod_next;
    logic signed [32:0]  acc_reg, acc_next;
    logic [16:0]         mix_reg, mix_next;
    logic                m_valid_reg, m_valid_next;
    atha_pkg::out_item_t out_reg, out_next;

    atha_pkg::weight_row_t ram_rdata, ram_wdata;
    logic                  ram_we;
    logic [POD_W-1:0]      ram_waddr;
    atha_pkg::div_req_t    div_req;
    atha_pkg::div_rsp_t    div_rsp;

    logic signed [15:0] angle_sel;
    logic signed [16:0] angle_ext;
    logic [16:0]        mag;
    logic               axis_zero, axis_sat;
    logic [15:0]        diff;
    logic signed [15:0] w_sel, a_sel;
    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] mul_res;
    logic [17:0]        amp_q;
    logic [7:0]         amp_val;
    logic               out_free;

    atha_weight_ram #(
        .DEPTH  (POD_COUNT),
        .ADDR_W (POD_W)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr   (pod_reg),
        .rdata   (ram_rdata)
    );

    atha_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // axis deadband and saturation tests
    always_comb begin
        case (axis_idx_reg)
            2'd0: angle_sel = angle_reg[0];
            2'd1: angle_sel = angle_reg[1];
            default: angle_sel = angle_reg[2];
        endcase
        angle_ext = 17'(angle_sel);
        mag = angle_sel[15] ? 17'(-angle_ext) : 17'(angle_ext);
        axis_zero = (mag <= {1'b0, deadband_reg}) || (full_scale_reg <= deadband_reg);
        axis_sat = (mag >= {1'b0, full_scale_reg});
        diff = 16'(mag - {1'b0, deadband_reg});
    end

    // divider request for the in-between case
    assign div_req.start = (state_reg == atha_pkg::ST_AXIS) && !axis_zero && !axis_sat;
    assign div_req.numer = {diff, 15'd0} - {15'd0, diff};
    assign div_req.denom = full_scale_reg - deadband_reg;

    // shared multiplier operand select
    always_comb begin
        case (term_reg)
            2'd0: begin
                w_sel = ram_rdata.pitch_w;
                a_sel = axis_reg[0];
            end
            2'd1: begin
                w_sel = ram_rdata.roll_w;
                a_sel = axis_reg[1];
            end
            2'd2: begin
                w_sel = ram_rdata.yaw_w;
                a_sel = axis_reg[2];
            end
            default: begin
                w_sel = '0;
                a_sel = '0;
            end
        endcase
        if (state_reg == atha_pkg::ST_AMPMUL) begin
            mul_a = $signed({1'b0, mix_reg});
            mul_b = $signed({10'd0, max_amp_reg});
        end else begin
            mul_a = 18'(w_sel);
            mul_b = 18'(a_sel);
        end
        mul_res = mul_a * mul_b;
    end

    // amplitude scale and clamp
    always_comb begin
        amp_q = atha_pkg::div_q15_full(prod_reg[31:0]);
        amp_val = (amp_q > {10'd0, max_amp_reg}) ? max_amp_reg : amp_q[7:0];
    end

    // row write path
    assign ram_we = (state_reg == atha_pkg::ST_IDLE) && s_valid && s_data.cmd
                    && (32'(s_data.row_pod) < POD_COUNT);
    assign ram_waddr = POD_W'(s_data.row_pod);
    assign ram_wdata = '{pitch_w: s_data.row_pitch_weight,
                         roll_w: s_data.row_roll_weight,
                         yaw_w: s_data.row_yaw_weight};

    assign out_free = !m_valid_reg || m_ready;

    // sequencer next state and datapath updates
    always_comb begin
        state_next = state_reg;
        angle_next = angle_reg;
        axis_next = axis_reg;
        axis_idx_next = axis_idx_reg;
        axis_neg_next = axis_neg_reg;
        pod_next = pod_reg;
        term_next = term_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        mix_next = mix_reg;
        out_next = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            atha_pkg::ST_IDLE: begin
                if (s_valid && !s_data.cmd) begin
                    angle_next[0] = s_data.pitch;
                    angle_next[1] = s_data.roll;
                    angle_next[2] = s_data.yaw;
                    axis_idx_next = 2'd0;
                    state_next = atha_pkg::ST_AXIS;
                end
            end
            atha_pkg::ST_AXIS: begin
                axis_neg_next = angle_sel[15];
                if (axis_zero || axis_sat) begin
                    case (axis_idx_reg)
                        2'd0: axis_next[0] = axis_zero ? 16'sd0 :
                            (angle_sel[15] ? -$signed(atha_pkg::Q15_FULL)
                                           : $signed(atha_pkg::Q15_FULL));
                        2'd1: axis_next[1] = axis_zero ? 16'sd0 :
                            (angle_sel[15] ? -$signed(atha_pkg::Q15_FULL)
                                           : $signed(atha_pkg::Q15_FULL));
                        default: axis_next[2] = axis_zero ? 16'sd0 :
                            (angle_sel[15] ? -$signed(atha_pkg::Q15_FULL)
                                           : $signed(atha_pkg::Q15_FULL));
                    endcase
                    if (axis_idx_reg == 2'd2) begin
                        pod_next = '0;
                        state_next = atha_pkg::ST_RD;
                    end else begin
                        axis_idx_next = axis_idx_reg + 2'd1;
                    end
                end else begin
                    state_next = atha_pkg::ST_AXDIV;
                end
            end
            atha_pkg::ST_AXDIV: begin
                if (div_rsp.done) begin
                    case (axis_idx_reg)
                        2'd0: axis_next[0] = axis_neg_reg ? -$signed({1'b0, div_rsp.quot})
                                                          : $signed({1'b0, div_rsp.quot});
                        2'd1: axis_next[1] = axis_neg_reg ? -$signed({1'b0, div_rsp.quot})
                                                          : $signed({1'b0, div_rsp.quot});
                        default: axis_next[2] = axis_neg_reg ? -$signed({1'b0, div_rsp.quot})
                                                             : $signed({1'b0, div_rsp.quot});
                    endcase
                    if (axis_idx_reg == 2'd2) begin
                        pod_next = '0;
                        state_next = atha_pkg::ST_RD;
                    end else begin
                        axis_idx_next = axis_idx_reg + 2'd1;
                        state_next = atha_pkg::ST_AXIS;
                    end
                end
            end
            atha_pkg::ST_RD: begin
                // weight row read in flight
                acc_next = '0;
                term_next = 2'd0;
                state_next = atha_pkg::ST_MAC;
            end
            atha_pkg::ST_MAC: begin
                // multiply one term, accumulate the previous one
                if (term_reg != 2'd3) begin
                    prod_next = 32'(mul_res);
                end
                if (term_reg != 2'd0) begin
                    acc_next = acc_reg + 33'(prod_reg);
                end
                if (term_reg == 2'd3) begin
                    state_next = atha_pkg::ST_MIXDIV;
                end else begin
                    term_next = term_reg + 2'd1;
                end
            end
            atha_pkg::ST_MIXDIV: begin
                // only a positive mix drives the pod
                if (!acc_reg[32] && (acc_reg != '0)) begin
                    mix_next = 17'(atha_pkg::div_q15_full(acc_reg[31:0]));
                end else begin
                    mix_next = '0;
                end
                state_next = atha_pkg::ST_AMPMUL;
            end
            atha_pkg::ST_AMPMUL: begin
                prod_next = 32'(mul_res);
                state_next = atha_pkg::ST_AMPDIV;
            end
            atha_pkg::ST_AMPDIV: begin
                if (out_free) begin
                    out_next.pod_index = 3'(pod_reg);
                    out_next.amplitude = amp_val;
                    out_next.last_pod = (pod_reg == LAST_POD);
                    m_valid_next = 1'b1;
                    if (pod_reg == LAST_POD) begin
                        state_next = atha_pkg::ST_IDLE;
                    end else begin
                        pod_next = pod_reg + 1'b1;
                        state_next = atha_pkg::ST_RD;
                    end
                end
            end
            default: state_next = atha_pkg::ST_IDLE;
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atha_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            deadband_reg <= atha_pkg::DEADBAND_RESET;
            full_scale_reg <= atha_pkg::FULL_SCALE_RESET;
            max_amp_reg <= atha_pkg::MAX_AMP_RESET;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    atha_pkg::CFG_DEADBAND: deadband_reg <= cfg_data;
                    atha_pkg::CFG_FULL_SCALE: full_scale_reg <= cfg_data;
                    atha_pkg::CFG_MAX_AMP: max_amp_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        angle_reg <= angle_next;
        axis_reg <= axis_next;
        axis_idx_reg <= axis_idx_next;
        axis_neg_reg <= axis_neg_next;
        pod_reg <= pod_next;
        term_reg <= term_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        mix_reg <= mix_next;
        out_reg <= out_next;
    end

    assign s_ready = (state_reg == atha_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;
    assign cfg_ready = 1'b1;

endmodule

/* hw/rtl/atha_checker.sv */
// port-level checks for the attitude to haptic amplitude unit, with bind
module atha_checker #(
    parameter int POD_COUNT = atha_pkg::POD_COUNT_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input atha_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input atha_pkg::out_item_t m_data
);

    localparam logic [2:0] LAST_IDX = 3'(POD_COUNT - 1);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a sample request makes the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.cmd |=> !s_ready)
        else $error("ready after sample request");

    // a row write request leaves the block idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.cmd |=> s_ready)
        else $error("busy after row write");

    // when idle, only the final pod of a sample may still wait
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && s_ready |-> m_data.last_pod)
        else $error("idle with a non-final pod pending");

    // final pod carries the last pod number
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_pod |-> m_data.pod_index == LAST_IDX)
        else $error("last pod flag on wrong pod");

endmodule

bind attitude_to_haptic_amplitudes_unit atha_checker #(
    .POD_COUNT (POD_COUNT)
) u_atha_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* tb/tb_attitude_to_haptic_amplitudes_unit.sv */
// self-checking testbench for the attitude to haptic amplitude unit
module tb_attitude_to_haptic_amplitudes_unit;

    localparam int POD_COUNT = atha_pkg::POD_COUNT_DEF;
    localparam int Q15 = atha_pkg::Q15_FULL;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int PAUSE_AT = 150;
    localparam int HOLD_AT = 500;
    localparam int HOLD_CYCLES = 600;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    atha_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    atha_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [15:0]         cfg_data = '0;

    // predictor state: registers and weight rows
    logic [15:0] db_reg;
    logic [15:0] fs_reg;
    logic [7:0]  max_reg;
    atha_pkg::weight_row_t pod_rows [POD_COUNT];

    atha_pkg::in_item_t  pending [$];
    atha_pkg::out_item_t expected_pods [$];
    int errors = 0;
    int items_sent = 0;
    int pods_seen = 0;
    int src_gap = 0;
    int snk_stall = 0;
    bit src_idle_en = 1'b1;
    bit snk_idle_en = 1'b1;

    attitude_to_haptic_amplitudes_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("attitude_to_haptic_amplitudes_unit test failed");
        $finish;
    end

    // deadband and Q15 scaling of one angle
    function automatic int scale_axis(input logic signed [15:0] v);
        int mag;
        int dbv;
        int fsv;
        int r;
        dbv = db_reg;
        fsv = fs_reg;
        mag = (v < 0) ? -int'(v) : int'(v);
        if (mag <= dbv || fsv <= dbv) return 0;
        if (mag >= fsv) r = Q15;
        else r = ((mag - dbv) * Q15) / (fsv - dbv);
        return (v < 0) ? -r : r;
    endfunction

    // row write or per-pod amplitudes for one accepted request
    function automatic void map_attitude(input atha_pkg::in_item_t it);
        int axes [3];
        longint mix;
        longint amp;
        atha_pkg::out_item_t res;
        if (it.cmd) begin
            if (int'(it.row_pod) < POD_COUNT) begin
                pod_rows[it.row_pod].pitch_w = it.row_pitch_weight;
                pod_rows[it.row_pod].roll_w = it.row_roll_weight;
                pod_rows[it.row_pod].yaw_w = it.row_yaw_weight;
            end
            return;
        end
        axes[0] = scale_axis(it.pitch);
        axes[1] = scale_axis(it.roll);
        axes[2] = scale_axis(it.yaw);
        for (int p = 0; p < POD_COUNT; p++) begin
            mix = longint'(pod_rows[p].pitch_w) * axes[0]
                + longint'(pod_rows[p].roll_w) * axes[1]
                + longint'(pod_rows[p].yaw_w) * axes[2];
            mix = mix / Q15;
            amp = 0;
            if (mix > 0) begin
                amp = (mix * longint'(max_reg)) / Q15;
                if (amp > longint'(max_reg)) amp = max_reg;
            end
            res.pod_index = 3'(p);
            res.amplitude = 8'(amp);
            res.last_pod = (p == POD_COUNT - 1);
            expected_pods.push_back(res);
        end
    endfunction

    // angle mix: extremes, around deadband and full scale, in span, random
    function automatic logic [15:0] rand_angle();
        int t;
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: t = int'(db_reg) + $urandom_range(0, 4) - 2;
            3: t = int'(fs_reg) + $urandom_range(0, 4) - 2;
            5: t = $urandom_range(0, int'(fs_reg));
            6: return 16'h0000;
            default: return 16'($urandom);
        endcase
        if ($urandom_range(0, 1)) t = -t;
        return 16'(t);
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 6))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h8001;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly attitude samples, some weight row writes
    function automatic atha_pkg::in_item_t rand_item();
        atha_pkg::in_item_t it;
        it.cmd = ($urandom_range(0, 3) == 0);
        it.pitch = rand_angle();
        it.roll = rand_angle();
        it.yaw = rand_angle();
        it.row_pod = 3'($urandom_range(0, 7));
        it.row_pitch_weight = rand_weight();
        it.row_roll_weight = rand_weight();
        it.row_yaw_weight = rand_weight();
        return it;
    endfunction

    function automatic atha_pkg::in_item_t sample(input int p, input int r, input int y);
        atha_pkg::in_item_t it;
        it = rand_item();
        it.cmd = 1'b0;
        it.pitch = 16'(p);
        it.roll = 16'(r);
        it.yaw = 16'(y);
        return it;
    endfunction

    function automatic atha_pkg::in_item_t row(input int pod, input int wp, input int wr,
                                               input int wy);
        atha_pkg::in_item_t it;
        it = rand_item();
        it.cmd = 1'b1;
        it.row_pod = 3'(pod);
        it.row_pitch_weight = 16'(wp);
        it.row_roll_weight = 16'(wr);
        it.row_yaw_weight = 16'(wy);
        return it;
    endfunction

    // register write over the config channel, predictor updated on accept
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            atha_pkg::CFG_DEADBAND: db_reg = val;
            atha_pkg::CFG_FULL_SCALE: fs_reg = val;
            atha_pkg::CFG_MAX_AMP: max_reg = val[7:0];
            default: ;
        endcase
    endtask

    // wait for every request sent and every pod result back, then let the block go quiet
    task automatic settle();
        while (pending.size() != 0 || s_valid || expected_pods.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_random(input int n);
        repeat (n) pending.push_back(rand_item());
    endtask

    // request driver
    always @(posedge aclk) begin : drive
        int gap_now;
        logic free;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            free = !s_valid;
            gap_now = src_gap;
            if (s_valid && s_ready) begin
                map_attitude(s_data);
                items_sent++;
                free = 1'b1;
                gap_now = src_idle_en ? $urandom_range(0, 17) : 0;
            end
            if (free) begin
                if (gap_now > 0) begin
                    s_valid <= 1'b0;
                    src_gap <= gap_now - 1;
                end else if (pending.size() != 0 &&
                             !(items_sent == PAUSE_AT && expected_pods.size() != 0)) begin
                    s_data <= pending.pop_front();
                    s_valid <= 1'b1;
                    src_gap <= 0;
                end else begin
                    s_valid <= 1'b0;
                    src_gap <= 0;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge aclk) begin : monitor
        atha_pkg::out_item_t want;
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                pods_seen++;
                if (expected_pods.size() == 0) begin
                    $error("unexpected result: pod_index %0d amplitude %0d",
                           m_data.pod_index, m_data.amplitude);
                    errors++;
                end else begin
                    want = expected_pods.pop_front();
                    if (m_data.pod_index !== want.pod_index) begin
                        $error("pod_index: expected %0d actual %0d",
                               want.pod_index, m_data.pod_index);
                        errors++;
                    end
                    if (m_data.amplitude !== want.amplitude) begin
                        $error("amplitude: expected %0d actual %0d",
                               want.amplitude, m_data.amplitude);
                        errors++;
                    end
                    if (m_data.last_pod !== want.last_pod) begin
                        $error("last_pod: expected %0d actual %0d",
                               want.last_pod, m_data.last_pod);
                        errors++;
                    end
                end
                if (pods_seen == HOLD_AT) w = HOLD_CYCLES;
                else w = snk_idle_en ? $urandom_range(0, 17) : 0;
            end else if (m_ready) begin
                w = 0;
            end else begin
                w = snk_stall;
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                snk_stall <= w - 1;
            end else begin
                m_ready <= 1'b1;
                snk_stall <= 0;
            end
        end
    end

    // reset, directed requests, then random phases over several register settings
    initial begin : stimulus
        logic [15:0] v;
        logic [15:0] lo;
        db_reg = atha_pkg::DEADBAND_RESET;
        fs_reg = atha_pkg::FULL_SCALE_RESET;
        max_reg = atha_pkg::MAX_AMP_RESET;
        foreach (pod_rows[p]) pod_rows[p] = '0;
        pod_rows[0].pitch_w = 16'(Q15);
        pod_rows[1].yaw_w = 16'(Q15);
        pod_rows[2].roll_w = 16'(Q15);
        pod_rows[4].pitch_w = 16'(-Q15);
        pod_rows[5].yaw_w = 16'(-Q15);
        pod_rows[6].roll_w = 16'(-Q15);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero, saturation, most negative angle, deadband and full scale edges
        pending.push_back(sample(0, 0, 0));
        pending.push_back(sample(32767, 0, 0));
        pending.push_back(sample(-32768, 0, 0));
        pending.push_back(sample(0, 350, -350));
        pending.push_back(sample(0, 351, -351));
        pending.push_back(sample(3499, -3499, 3500));
        pending.push_back(sample(-3500, 3501, -32768));
        pending.push_back(sample(32767, 32767, 32767));
        pending.push_back(sample(-32768, -32768, -32768));
        // row writes with extreme weights, then samples that hit the clamp
        pending.push_back(row(3, 32767, 32767, 32767));
        pending.push_back(sample(32767, 32767, 32767));
        pending.push_back(row(7, -32768, -32768, -32768));
        pending.push_back(sample(-32768, -32768, -32768));
        pending.push_back(row(0, -32768, 16384, 0));
        pending.push_back(sample(-1000, 2000, 0));
        pending.push_back(row(5, 0, 0, 0));
        pending.push_back(sample(1925, -1925, 0));
        pending.push_back(row(2, 1, -1, 32767));
        pending.push_back(sample(360, -360, 3400));
        pending.push_back(sample(-360, 360, -3400));
        pending.push_back(row(1, 0, 0, 0));
        settle();

        // widest span, largest amplitude, upper data bits set on the 8-bit register
        write_reg(atha_pkg::CFG_DEADBAND, 16'd0);
        write_reg(atha_pkg::CFG_FULL_SCALE, 16'hffff);
        lo = 16'($urandom_range(1, 255));
        write_reg(atha_pkg::CFG_MAX_AMP, {lo[7:0], 8'hff});
        push_random(55);
        settle();

        // narrowest span, no idling on either side
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        write_reg(atha_pkg::CFG_DEADBAND, 16'd100);
        write_reg(atha_pkg::CFG_FULL_SCALE, 16'd101);
        write_reg(atha_pkg::CFG_MAX_AMP, 16'd1);
        push_random(55);
        settle();

        // degenerate span with full scale equal to deadband
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        write_reg(atha_pkg::CFG_DEADBAND, 16'd5000);
        write_reg(atha_pkg::CFG_FULL_SCALE, 16'd5000);
        write_reg(atha_pkg::CFG_MAX_AMP, 16'd200);
        push_random(30);
        settle();

        // degenerate span the other way round, zero amplitude, unused index
        write_reg(atha_pkg::CFG_DEADBAND, 16'hffff);
        write_reg(atha_pkg::CFG_FULL_SCALE, 16'd0);
        write_reg(atha_pkg::CFG_MAX_AMP, 16'd0);
        write_reg(CFG_UNUSED, 16'($urandom));
        push_random(25);
        settle();

        // random settings
        repeat (3) begin
            v = 16'($urandom_range(0, 3000));
            write_reg(atha_pkg::CFG_DEADBAND, v);
            write_reg(atha_pkg::CFG_FULL_SCALE, 16'($urandom_range(int'(v) + 1, 40000)));
            write_reg(atha_pkg::CFG_MAX_AMP, 16'($urandom_range(0, 255)));
            push_random(55);
            settle();
        end

        if (errors == 0)
            $display("attitude_to_haptic_amplitudes_unit test passed");
        else
            $display("attitude_to_haptic_amplitudes_unit test failed");
        $finish;
    end

endmodule
